[rtl/core/wmix_pkg.sv]
`timescale 1ns / 1ps

package wmix_pkg;

  localparam int OSC_COUNT_DEF         = 4;
  localparam int NOTE_COUNT_DEF        = 128;
  localparam int TABLE_SIZE_DEF        = 1024;
  localparam int SAMPLE_RATE_HZ_DEF    = 48000;
  localparam int BASE_FREQ_MILLIHZ_DEF = 8176;

  localparam int NOTE_W   = 7;
  localparam int OFFS_W   = 7;
  localparam int GAIN_W   = 16;
  localparam int SAMPLE_W = 16;
  localparam int SCALED_W = 18;
  localparam int MIX_W    = 18;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam logic [2:0] REG_ENABLE   = 3'd0;
  localparam logic [2:0] REG_WAVE_SEL = 3'd1;
  localparam logic [2:0] REG_SEMITONE = 3'd2;
  localparam logic [2:0] REG_AMP_A    = 3'd3;
  localparam logic [2:0] REG_AMP_B    = 3'd4;

  localparam logic [1:0] WAVE_SINE   = 2'd0;
  localparam logic [1:0] WAVE_SAW    = 2'd1;
  localparam logic [1:0] WAVE_SQUARE = 2'd2;
  localparam logic [1:0] WAVE_SILENT = 2'd3;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic load_b;
    logic load_c;
    logic load_d;
  } wmix_stage_t;

  // Equal-tempered semitone ratios 2^(k/12) in Q30.
  function automatic logic [63:0] semitone_ratio(input int k);
    logic [63:0] r;
    unique case (k)
      0:       r = 64'd1073741824;
      1:       r = 64'd1137589835;
      2:       r = 64'd1205234447;
      3:       r = 64'd1276901417;
      4:       r = 64'd1352829926;
      5:       r = 64'd1433273380;
      6:       r = 64'd1518500250;
      7:       r = 64'd1608794974;
      8:       r = 64'd1704458901;
      9:       r = 64'd1805811301;
      10:      r = 64'd1913190429;
      11:      r = 64'd2026954652;
      default: r = 64'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/wmix_if.sv]
`timescale 1ns / 1ps

interface wmix_note_if;
  logic                           valid;
  logic                           ready;
  logic [wmix_pkg::NOTE_W-1:0]    note_number;

  modport source (output valid, output note_number, input ready);
  modport sink (input valid, input note_number, output ready);
endinterface

interface wmix_mix_if;
  logic                           valid;
  logic                           ready;
  logic signed [wmix_pkg::MIX_W-1:0] mixed_sample;
  logic                           clipped;

  modport source (output valid, output mixed_sample, output clipped, input ready);
  modport sink (input valid, input mixed_sample, input clipped, output ready);
endinterface

[rtl/core/wmix_osc.sv]
`timescale 1ns / 1ps

module wmix_osc #(
  parameter int NOTE_COUNT        = wmix_pkg::NOTE_COUNT_DEF,
  parameter int TABLE_SIZE        = wmix_pkg::TABLE_SIZE_DEF,
  parameter int SAMPLE_RATE_HZ    = wmix_pkg::SAMPLE_RATE_HZ_DEF,
  parameter int BASE_FREQ_MILLIHZ = wmix_pkg::BASE_FREQ_MILLIHZ_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  wmix_pkg::wmix_stage_t                stage,
  input  logic [wmix_pkg::NOTE_W-1:0]          note,
  input  logic                                 enable,
  input  logic [1:0]                           wave_sel,
  input  logic [wmix_pkg::OFFS_W-1:0]          offset,
  input  logic [wmix_pkg::GAIN_W-1:0]          gain,
  output logic signed [wmix_pkg::SCALED_W-1:0] scaled
);
  import wmix_pkg::*;

  localparam int IDX_W     = $clog2(TABLE_SIZE);
  localparam int NIDX_W    = $clog2(NOTE_COUNT);
  localparam logic [63:0] INC_DIVISOR = 64'(1000) * 64'(SAMPLE_RATE_HZ);
  localparam logic [IDX_W-1:0] SQUARE_EDGE = IDX_W'(TABLE_SIZE / 2);

  typedef logic [31:0] inc_tab_t [NOTE_COUNT];
  typedef logic [SAMPLE_W-1:0] sine_rom_t [TABLE_SIZE];

  function automatic inc_tab_t build_inc();
    inc_tab_t    tab;
    logic [63:0] num;
    for (int n = 0; n < NOTE_COUNT; n++) begin
      num = 64'(BASE_FREQ_MILLIHZ) * semitone_ratio(n % 12);
      num = num << (n / 12);
      num = num << 2;
      tab[n] = 32'(num / INC_DIVISOR);
    end
    return tab;
  endfunction

  function automatic sine_rom_t build_sine();
    sine_rom_t   rom;
    logic [63:0] p;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    logic [1:0]  q;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      p = (64'(i) << 32) / 64'(TABLE_SIZE);
      q = p[31:30];
      r = {34'd0, p[29:0]};
      if (q[0]) begin
        r = Q30_ONE - r;
      end
      x  = (r * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - (((x2 * t) >> 30) / 110);
      t  = Q30_ONE - (((x2 * t) >> 30) / 72);
      t  = Q30_ONE - (((x2 * t) >> 30) / 42);
      t  = Q30_ONE - (((x2 * t) >> 30) / 20);
      t  = Q30_ONE - (((x2 * t) >> 30) / 6);
      s  = (x * t) >> 30;
      v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      rom[i] = q[1] ? SAMPLE_W'(-v) : SAMPLE_W'(v);
    end
    return rom;
  endfunction

  localparam inc_tab_t  INC_TAB  = build_inc();
  localparam sine_rom_t SINE_ROM = build_sine();

  logic [31:0]              phase;
  logic [31:0]              phase_next;
  logic [NOTE_W:0]          note_sum;
  logic [NIDX_W-1:0]        note_idx;
  logic [IDX_W-1:0]         idx;
  logic [1:0]               sel;
  logic                     active;
  logic signed [SAMPLE_W-1:0] sample;
  logic [15:0]              saw_u;
  logic signed [32:0]       product;

  always_comb begin
    note_sum = {1'b0, note} + {1'b0, offset};
    if (note_sum > (NOTE_W + 1)'(NOTE_COUNT - 1)) begin
      note_idx = NIDX_W'(NOTE_COUNT - 1);
    end else begin
      note_idx = note_sum[NIDX_W-1:0];
    end
    phase_next = phase + INC_TAB[note_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (stage.load_b && enable) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (stage.load_b) begin
      idx    <= phase_next[31 -: IDX_W];
      sel    <= wave_sel;
      active <= enable && (wave_sel != WAVE_SILENT);
    end
  end

  assign saw_u = 16'((32'(idx) << 16) >> IDX_W);

  always_ff @(posedge clk) begin
    if (stage.load_c) begin
      if (!active) begin
        sample <= '0;
      end else begin
        unique case (sel)
          WAVE_SINE:   sample <= SINE_ROM[idx];
          WAVE_SAW:    sample <= {~saw_u[15], saw_u[14:0]};
          WAVE_SQUARE: sample <= (idx > SQUARE_EDGE) ? 16'sh7fff : 16'sh8000;
          default:     sample <= '0;
        endcase
      end
    end
  end

  assign product = 33'(sample) * $signed({17'd0, gain});

  always_ff @(posedge clk) begin
    if (stage.load_d) begin
      scaled <= product[32:15];
    end
  end

endmodule

[rtl/core/wavetable_oscillator_mixer.sv]
`timescale 1ns / 1ps

// Channel  Modport  Payload                        Transfer
// notes    sink     note_number[6:0]               valid && ready
// mix      source   mixed_sample[17:0], clipped    valid && ready
// apb      slave    paddr[4:0], pwdata, prdata     psel && penable && pwrite (write)
//
// One note is accepted per cycle while the output does not stall.
// The stages are note register, phase advance, wavetable read, gain multiply and
// mix with saturation. The phase accumulators advance in the phase stage.
// A stalled output holds its stage; earlier stages keep filling until all are full.
// Synchronous reset clears the phases, the APB registers and all stage valid bits.

module wavetable_oscillator_mixer #(
  parameter int OSC_COUNT         = wmix_pkg::OSC_COUNT_DEF,
  parameter int NOTE_COUNT        = wmix_pkg::NOTE_COUNT_DEF,
  parameter int TABLE_SIZE        = wmix_pkg::TABLE_SIZE_DEF,
  parameter int SAMPLE_RATE_HZ    = wmix_pkg::SAMPLE_RATE_HZ_DEF,
  parameter int BASE_FREQ_MILLIHZ = wmix_pkg::BASE_FREQ_MILLIHZ_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  wmix_note_if.sink                         notes,
  wmix_mix_if.source                        mix,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wmix_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [wmix_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [wmix_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import wmix_pkg::*;

  localparam int SUM_W = SCALED_W + 2;

  logic [3:0]  enable_mask;
  logic [7:0]  wave_sels;
  logic [27:0] semitones;
  logic [63:0] amps;
  logic [2:0]  reg_idx;

  logic        va;
  logic        vb;
  logic        vc;
  logic        vd;
  logic        ve;
  logic        free_a;
  logic        free_b;
  logic        free_c;
  logic        free_d;
  logic        free_e;
  logic        load_a;
  logic        load_e;
  wmix_stage_t stage;

  logic [NOTE_W-1:0]          note_a;
  logic signed [SCALED_W-1:0] scaled [OSC_COUNT];
  logic signed [SUM_W-1:0]    sum;
  logic signed [MIX_W-1:0]    mixed;
  logic                       clip;

  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask <= '0;
      wave_sels   <= '0;
      semitones   <= '0;
      amps        <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_ENABLE:   enable_mask   <= pwdata[3:0];
        REG_WAVE_SEL: wave_sels     <= pwdata[7:0];
        REG_SEMITONE: semitones     <= pwdata[27:0];
        REG_AMP_A:    amps[31:0]    <= pwdata;
        REG_AMP_B:    amps[63:32]   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ENABLE:   prdata = {28'd0, enable_mask};
      REG_WAVE_SEL: prdata = {24'd0, wave_sels};
      REG_SEMITONE: prdata = {4'd0, semitones};
      REG_AMP_A:    prdata = amps[31:0];
      REG_AMP_B:    prdata = amps[63:32];
      default:      prdata = '0;
    endcase
  end

  // Each stage loads from its predecessor when it is empty or its own item moves on in the same cycle.
  always_comb begin
    free_e       = !ve || mix.ready;
    free_d       = !vd || free_e;
    free_c       = !vc || free_d;
    free_b       = !vb || free_c;
    free_a       = !va || free_b;
    load_a       = notes.valid && free_a;
    stage.load_b = va && free_b;
    stage.load_c = vb && free_c;
    stage.load_d = vc && free_d;
    load_e       = vd && free_e;
  end

  assign notes.ready = free_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
    end else begin
      va <= load_a || (va && !stage.load_b);
      vb <= stage.load_b || (vb && !stage.load_c);
      vc <= stage.load_c || (vc && !stage.load_d);
      vd <= stage.load_d || (vd && !load_e);
      ve <= load_e || (ve && !mix.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (load_a) begin
      note_a <= notes.note_number;
    end
  end

  for (genvar k = 0; k < OSC_COUNT; k++) begin : g_osc
    wmix_osc #(
      .NOTE_COUNT        (NOTE_COUNT),
      .TABLE_SIZE        (TABLE_SIZE),
      .SAMPLE_RATE_HZ    (SAMPLE_RATE_HZ),
      .BASE_FREQ_MILLIHZ (BASE_FREQ_MILLIHZ)
    ) u_osc (
      .clk      (clk),
      .rst      (rst),
      .stage    (stage),
      .note     (note_a),
      .enable   (enable_mask[k]),
      .wave_sel (wave_sels[2*k +: 2]),
      .offset   (semitones[7*k +: 7]),
      .gain     (amps[16*k +: 16]),
      .scaled   (scaled[k])
    );
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < OSC_COUNT; k++) begin
      sum = sum + SUM_W'(scaled[k]);
    end
    if (sum > SUM_W'(131071)) begin
      mixed = 18'sh1ffff;
      clip  = 1'b1;
    end else if (sum < -SUM_W'(131072)) begin
      mixed = 18'sh20000;
      clip  = 1'b1;
    end else begin
      mixed = sum[MIX_W-1:0];
      clip  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_e) begin
      mix.mixed_sample <= mixed;
      mix.clipped      <= clip;
    end
  end

  assign mix.valid = ve;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import wmix_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int IDX_W = $clog2(TABLE_SIZE_DEF);
  localparam int NIDX_W = $clog2(NOTE_COUNT_DEF);
  localparam int MIX_MAX = 131071;
  localparam int MIX_MIN = -131072;
  localparam logic [2:0] REG_SPARE = 3'd5;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;

  typedef struct packed {
    logic signed [MIX_W-1:0] sample;
    logic clipped;
  } mix_result_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  wmix_note_if notes_if();
  wmix_mix_if mix_if();

  wavetable_oscillator_mixer dut (
    .clk(clk),
    .rst(rst),
    .notes(notes_if),
    .mix(mix_if),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  logic [31:0] ratio_q30 [12] = '{
    32'd1073741824, 32'd1137589835, 32'd1205234447, 32'd1276901417,
    32'd1352829926, 32'd1433273380, 32'd1518500250, 32'd1608794974,
    32'd1704458901, 32'd1805811301, 32'd1913190429, 32'd2026954652
  };
  logic [31:0] inc_rom [NOTE_COUNT_DEF];
  logic signed [15:0] sine_rom [TABLE_SIZE_DEF];
  logic [31:0] osc_phase [OSC_COUNT_DEF];

  logic [3:0] cfg_enable;
  logic [7:0] cfg_wave;
  logic [27:0] cfg_semi;
  logic [31:0] cfg_amp_a;
  logic [31:0] cfg_amp_b;

  mix_result_t expected_mix [$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int holdoff_cycles = 0;
  bit sender_idling = 1'b1;
  bit receiver_idling = 1'b1;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic build_tables();
    logic [63:0] num;
    logic [63:0] p;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    for (int n = 0; n < NOTE_COUNT_DEF; n++) begin
      num = 64'(BASE_FREQ_MILLIHZ_DEF);
      num = num * 64'(ratio_q30[4'(n % 12)]);
      num = num << (n / 12 + 2);
      num = num / (64'd1000 * 64'(SAMPLE_RATE_HZ_DEF));
      inc_rom[n] = num[31:0];
    end
    for (int i = 0; i < TABLE_SIZE_DEF; i++) begin
      p = 64'(i);
      p = (p << 32) / 64'(TABLE_SIZE_DEF);
      r = {34'd0, p[29:0]};
      if (p[30]) begin
        r = ONE_Q30 - r;
      end
      x = (r * QUARTER_TURN_Q30) >> 30;
      x2 = (x * x) >> 30;
      t = ONE_Q30;
      t = ONE_Q30 - (((x2 * t) >> 30) / 64'd110);
      t = ONE_Q30 - (((x2 * t) >> 30) / 64'd72);
      t = ONE_Q30 - (((x2 * t) >> 30) / 64'd42);
      t = ONE_Q30 - (((x2 * t) >> 30) / 64'd20);
      t = ONE_Q30 - (((x2 * t) >> 30) / 64'd6);
      s = (x * t) >> 30;
      v = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      sine_rom[i] = p[31] ? -v[15:0] : v[15:0];
    end
  endtask

  function automatic mix_result_t predict_mix_tick(input logic [NOTE_W-1:0] note);
    mix_result_t res;
    logic [7:0] n;
    logic [IDX_W-1:0] idx;
    logic [1:0] wave;
    int gain;
    int samp;
    int total;
    total = 0;
    for (int k = 0; k < OSC_COUNT_DEF; k++) begin
      if (cfg_enable[k]) begin
        n = {1'b0, note} + {1'b0, cfg_semi[7*k +: 7]};
        if (n > NOTE_COUNT_DEF - 1) begin
          n = 8'(NOTE_COUNT_DEF - 1);
        end
        osc_phase[k] = osc_phase[k] + inc_rom[n[NIDX_W-1:0]];
        idx = osc_phase[k][31 -: IDX_W];
        wave = cfg_wave[2*k +: 2];
        if (k < 2) begin
          gain = int'(cfg_amp_a[16*k +: 16]);
        end else begin
          gain = int'(cfg_amp_b[16*(k-2) +: 16]);
        end
        case (wave)
          WAVE_SINE: samp = int'(sine_rom[idx]);
          WAVE_SAW: begin
            samp = int'(idx);
            samp = samp * 65536 / TABLE_SIZE_DEF - 32768;
          end
          WAVE_SQUARE: samp = (idx > TABLE_SIZE_DEF / 2) ? 32767 : -32768;
          default: samp = 0;
        endcase
        total = total + ((samp * gain) >>> 15);
      end
    end
    res.clipped = 1'b0;
    if (total > MIX_MAX) begin
      total = MIX_MAX;
      res.clipped = 1'b1;
    end else if (total < MIX_MIN) begin
      total = MIX_MIN;
      res.clipped = 1'b1;
    end
    res.sample = total[MIX_W-1:0];
    return res;
  endfunction

  task automatic note_mismatch(input string what, input longint want, input longint got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && notes_if.valid && notes_if.ready) begin
      expected_mix.push_back(predict_mix_tick(notes_if.note_number));
    end
  end

  always @(posedge clk) begin : mix_checker
    mix_result_t want;
    if (!rst && mix_if.valid && mix_if.ready) begin
      if (expected_mix.size() == 0) begin
        note_mismatch("result with nothing expected", 0, mix_if.mixed_sample);
      end else begin
        want = expected_mix.pop_front();
        if (mix_if.mixed_sample !== want.sample) begin
          note_mismatch("mixed_sample", want.sample, mix_if.mixed_sample);
        end
        if (mix_if.clipped !== want.clipped) begin
          note_mismatch("clipped", want.clipped, mix_if.clipped);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : mix_receiver
    int stall;
    mix_if.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (holdoff_cycles > 0) begin
        stall = holdoff_cycles;
        holdoff_cycles = 0;
      end else begin
        stall = receiver_idling ? $urandom_range(0, 5) : 0;
      end
      if (stall > 0) begin
        mix_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      mix_if.ready <= 1'b1;
      @(posedge clk);
      while (!mix_if.valid) @(posedge clk);
    end
  end

  task automatic send_note(input logic [NOTE_W-1:0] note);
    int gap;
    gap = sender_idling ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      notes_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    notes_if.valid <= 1'b1;
    notes_if.note_number <= note;
    @(posedge clk);
    while (!notes_if.ready) @(posedge clk);
  endtask

  task automatic wait_mix_drained();
    notes_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_mix.size() != 0) @(posedge clk);
  endtask

  task automatic apb_check_reg(input logic [2:0] reg_idx);
    logic [31:0] want;
    case (reg_idx)
      REG_ENABLE: want = {28'd0, cfg_enable};
      REG_WAVE_SEL: want = {24'd0, cfg_wave};
      REG_SEMITONE: want = {4'd0, cfg_semi};
      REG_AMP_A: want = cfg_amp_a;
      default: want = cfg_amp_b;
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {reg_idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      note_mismatch("register readback", want, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] reg_idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (reg_idx)
      REG_ENABLE: cfg_enable = value[3:0];
      REG_WAVE_SEL: cfg_wave = value[7:0];
      REG_SEMITONE: cfg_semi = value[27:0];
      REG_AMP_A: cfg_amp_a = value;
      REG_AMP_B: cfg_amp_b = value;
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (reg_idx <= REG_AMP_B) begin
      apb_check_reg(reg_idx);
    end
  endtask

  function automatic logic [31:0] pick_value(input int width);
    logic [31:0] all_ones;
    all_ones = (width >= 32) ? 32'hFFFF_FFFF : (32'd1 << width) - 32'd1;
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return all_ones;
      default: return $urandom() & all_ones;
    endcase
  endfunction

  task automatic randomize_config();
    logic [31:0] offs;
    logic [31:0] amp_a;
    logic [31:0] amp_b;
    offs = 32'd0;
    for (int k = 0; k < OSC_COUNT_DEF; k++) begin
      offs[7*k +: 7] = 7'(pick_value(7));
    end
    amp_a = {16'(pick_value(16)), 16'(pick_value(16))};
    amp_b = {16'(pick_value(16)), 16'(pick_value(16))};
    apb_write(REG_ENABLE, pick_value(4));
    apb_write(REG_WAVE_SEL, $urandom_range(0, 255));
    apb_write(REG_SEMITONE, offs);
    apb_write(REG_AMP_A, amp_a);
    apb_write(REG_AMP_B, amp_b);
  endtask

  task automatic test_reset_and_disabled();
    apb_check_reg(REG_ENABLE);
    apb_check_reg(REG_WAVE_SEL);
    apb_check_reg(REG_SEMITONE);
    apb_check_reg(REG_AMP_A);
    apb_check_reg(REG_AMP_B);
    send_note(7'd0);
    send_note(7'd127);
    wait_mix_drained();
    apb_write(REG_WAVE_SEL, 32'({4{WAVE_SQUARE}}));
    apb_write(REG_AMP_A, 32'hFFFF_FFFF);
    apb_write(REG_AMP_B, 32'hFFFF_FFFF);
    send_note(7'd64);
    send_note(7'd127);
    wait_mix_drained();
  endtask

  task automatic test_waveform_slots();
    logic [7:0] layouts [4];
    layouts[0] = {WAVE_SILENT, WAVE_SQUARE, WAVE_SAW, WAVE_SINE};
    layouts[1] = {WAVE_SINE, WAVE_SILENT, WAVE_SQUARE, WAVE_SAW};
    layouts[2] = {WAVE_SAW, WAVE_SINE, WAVE_SILENT, WAVE_SQUARE};
    layouts[3] = {WAVE_SQUARE, WAVE_SAW, WAVE_SINE, WAVE_SILENT};
    apb_write(REG_ENABLE, 32'hF);
    apb_write(REG_SEMITONE, 32'd0);
    apb_write(REG_AMP_A, {16'hFFFF, 16'h8000});
    apb_write(REG_AMP_B, {16'h0000, 16'h4000});
    for (int rot = 0; rot < 4; rot++) begin
      apb_write(REG_WAVE_SEL, 32'(layouts[rot]));
      send_note(7'd60);
      send_note(7'd127);
      wait_mix_drained();
    end
  endtask

  task automatic test_note_clamp();
    apb_write(REG_SEMITONE, 32'({7'd1, 7'd127, 7'd0, 7'd127}));
    apb_write(REG_WAVE_SEL, 32'({4{WAVE_SAW}}));
    send_note(7'd127);
    send_note(7'd0);
    send_note(7'd1);
    wait_mix_drained();
  endtask

  task automatic test_mix_saturation();
    apb_write(REG_SEMITONE, 32'd0);
    apb_write(REG_AMP_A, 32'hFFFF_FFFF);
    apb_write(REG_AMP_B, 32'hFFFF_FFFF);
    apb_write(REG_WAVE_SEL, 32'({4{WAVE_SQUARE}}));
    repeat (6) send_note(7'd127);
    wait_mix_drained();
    apb_write(REG_WAVE_SEL, 32'({4{WAVE_SAW}}));
    repeat (4) send_note(7'd100);
    wait_mix_drained();
  endtask

  task automatic test_register_map();
    apb_write(REG_ENABLE, 32'hFFFF_FFFF);
    apb_write(REG_WAVE_SEL, 32'hFFFF_FFFF);
    apb_write(REG_SEMITONE, 32'hFFFF_FFFF);
    apb_write(REG_AMP_A, 32'h1234_5678);
    apb_write(REG_AMP_B, 32'h8765_4321);
    apb_write(REG_WAVE_SEL, 32'({WAVE_SINE, WAVE_SAW, WAVE_SQUARE, WAVE_SINE}));
    apb_write(REG_SPARE, 32'hFFFF_FFFF);
    apb_check_reg(REG_ENABLE);
    apb_check_reg(REG_WAVE_SEL);
    apb_check_reg(REG_SEMITONE);
    apb_check_reg(REG_AMP_A);
    apb_check_reg(REG_AMP_B);
    repeat (10) send_note(7'($urandom_range(0, 127)));
    wait_mix_drained();
  endtask

  task automatic test_random_phases();
    logic [NOTE_W-1:0] note;
    note = '0;
    sender_idling = 1'b1;
    receiver_idling = 1'b1;
    for (int phase = 0; phase < 8; phase++) begin
      wait_mix_drained();
      randomize_config();
      for (int i = 0; i < 90; i++) begin
        if ($urandom_range(0, 3) != 0) begin
          note = 7'($urandom_range(0, 127));
        end
        send_note(note);
      end
    end
    wait_mix_drained();
  endtask

  task automatic test_full_rate();
    randomize_config();
    sender_idling = 1'b0;
    receiver_idling = 1'b0;
    repeat (60) send_note(7'($urandom_range(0, 127)));
    wait_mix_drained();
    sender_idling = 1'b1;
    receiver_idling = 1'b1;
  endtask

  task automatic test_output_backpressure();
    randomize_config();
    apb_write(REG_ENABLE, 32'hF);
    sender_idling = 1'b0;
    holdoff_cycles = 80;
    repeat (60) send_note(7'($urandom_range(0, 127)));
    wait_mix_drained();
    sender_idling = 1'b1;
  endtask

  task automatic test_sender_pause();
    repeat (30) send_note(7'($urandom_range(0, 127)));
    wait_mix_drained();
    repeat (30) send_note(7'($urandom_range(0, 127)));
    wait_mix_drained();
  endtask

  initial begin : stimulus
    rst = 1'b1;
    notes_if.valid = 1'b0;
    notes_if.note_number = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_enable = '0;
    cfg_wave = '0;
    cfg_semi = '0;
    cfg_amp_a = '0;
    cfg_amp_b = '0;
    for (int k = 0; k < OSC_COUNT_DEF; k++) begin
      osc_phase[k] = 32'd0;
    end
    build_tables();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_and_disabled();
    test_waveform_slots();
    test_note_clamp();
    test_mix_saturation();
    test_register_map();
    test_random_phases();
    test_full_rate();
    test_output_backpressure();
    test_sender_pause();

    wait_mix_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_mix.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/wmix_pkg.sv
rtl/core/wmix_if.sv
rtl/core/wmix_osc.sv
rtl/core/wavetable_oscillator_mixer.sv
tb/tb.sv
